FILE: rtl/core/sprite_palette_pixel_decoder_defines.svh
// assertion macros used by the checker file
`ifndef SPRITE_PALETTE_PIXEL_DECODER_DEFINES_SVH
`define SPRITE_PALETTE_PIXEL_DECODER_DEFINES_SVH

// same-cycle implication, off during reset
`define SPPD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sppd assertion failed");

// next-cycle implication, off during reset
`define SPPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sppd assertion failed");

// next-cycle implication, also checked across reset
`define SPPD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sppd assertion failed");

`endif

FILE: rtl/core/sppd_pkg.sv
`timescale 1ns / 1ps

package sppd_pkg;

  // item operations
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // color modes, draw_mode bits 5:3
  localparam logic [2:0] MODE_BANK4 = 3'd0;
  localparam logic [2:0] MODE_LUT4  = 3'd1;
  localparam logic [2:0] MODE_BANK8 = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_DRAW_MODE  = 2'd0;
  localparam logic [1:0] CFG_COLOR_BASE = 2'd1;
  localparam logic [1:0] CFG_TEX_WIDTH  = 2'd2;

  // draw_mode bit positions
  localparam int DM_END_OFF_BIT = 5;
  localparam int DM_SPD_BIT     = 6;
  localparam int DM_ENDC_BIT    = 7;
  localparam int DM_MSB_BIT     = 15;

  localparam logic [7:0]  TRANSPARENT_DOT = 8'h00;
  localparam logic [7:0]  LUT_END_DOT     = 8'h0F;
  localparam logic [1:0]  END_CODE_LIMIT  = 2'd2;
  localparam logic [8:0]  TEX_WIDTH_RESET = 9'd8;
  localparam logic [31:0] OPAQUE_BLACK    = 32'hFF00_0000;

  typedef enum logic [1:0] {
    PK_ZERO,
    PK_BANK,
    PK_LUT
  } pix_kind_t;

  typedef struct packed {
    pix_kind_t kind;
    logic      msb;
    logic      last;
  } pix_tag_t;

  function automatic logic [31:0] expand555(input logic [15:0] c);
    expand555 = {8'hFF, c[14:10], 3'b000, c[9:5], 3'b000, c[4:0], 3'b000};
  endfunction

endpackage

FILE: rtl/core/sppd_if.sv
`timescale 1ns / 1ps

interface sppd_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [10:0] table_index;
  logic [15:0] table_word;
  logic [7:0]  source_byte;

  modport source(output valid, op, table_index, table_word, source_byte, input ready);
  modport sink(input valid, op, table_index, table_word, source_byte, output ready);
endinterface

interface sppd_pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_rgba;
  logic        last_of_item;

  modport source(output valid, pixel_rgba, last_of_item, input ready);
  modport sink(input valid, pixel_rgba, last_of_item, output ready);
endinterface

FILE: rtl/core/sprite_palette_pixel_decoder.sv
`timescale 1ns / 1ps

// Paletted sprite dot decoder, RGB555 table to RGBA8888 pixels. A write request
// stores a word in the color table; an 8bpp bank byte yields one dot and a 4bpp
// byte (bank or lookup-table mode) two, high nibble first. The single read port
// of the color table serves one dot per cycle while the table read stage is free.
// A pixel passes from the input register through the table read stage to the
// output register. The table read stage and the output register hold up to two
// pixels; once both are full while the pixel side stalls, a decode request waits
// in the input register and holds off further input requests. Bytes in
// unsupported color modes are consumed with no output. The table has TABLE_WORDS
// entries (a power of two), indexes wrap modulo its size, and its contents are
// undefined until written; there is no clearing pass. Any configuration write to
// a defined index restarts the row, and must happen while the block is idle.
module sprite_palette_pixel_decoder #(
  parameter int TABLE_WORDS = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  sppd_item_if.sink           item,
  sppd_pixel_if.source        pixel
);

  localparam int AW = $clog2(TABLE_WORDS);

  // configuration and row state
  logic [15:0] draw_mode;
  logic [15:0] color_base;
  logic [8:0]  texture_width;
  logic [8:0]  column_count;
  logic [1:0]  end_code_count;
  logic [1:0]  end_code_count_next;

  // input register
  logic        a_valid;
  logic        a_phase;
  logic        a_op;
  logic [10:0] a_index;
  logic [15:0] a_word;
  logic [7:0]  a_byte;

  // table read stage and output register
  logic               b_valid;
  sppd_pkg::pix_tag_t b_tag;
  logic               c_valid;
  logic [31:0]        c_rgba;
  logic               c_last;

  logic [2:0]  mode;
  logic        is_4bpp;
  logic        supported;
  logic        is_write;
  logic        is_dec;
  logic [7:0]  dot;
  logic        c_free;
  logic        b_free;
  logic        issue;
  logic        a_done;
  logic        accept;
  logic [9:0]  col_sum;
  logic        row_end;
  logic [17:0] addr_full;
  logic [17:0] widx;
  sppd_pkg::pix_kind_t kind;
  logic [15:0] rdata;
  logic [31:0] rgba_comb;

  assign mode      = draw_mode[5:3];
  assign is_4bpp   = (mode == sppd_pkg::MODE_BANK4) || (mode == sppd_pkg::MODE_LUT4);
  assign supported = is_4bpp || (mode == sppd_pkg::MODE_BANK8);
  assign is_write  = a_valid && (a_op == sppd_pkg::OP_WRITE);
  assign is_dec    = a_valid && (a_op == sppd_pkg::OP_DECODE);
  assign dot       = (mode == sppd_pkg::MODE_BANK8) ? a_byte :
                     {4'b0000, (a_phase ? a_byte[3:0] : a_byte[7:4])};

  assign c_free = !c_valid || pixel.ready;
  assign b_free = !b_valid || c_free;
  assign issue  = is_dec && supported && b_free;
  assign a_done = is_write || (is_dec && !supported) ||
                  (issue && (!is_4bpp || a_phase));
  assign item.ready = !a_valid || a_done;
  assign accept     = item.valid && item.ready;

  assign col_sum = {1'b0, column_count} + (is_4bpp ? 10'd2 : 10'd1);
  assign row_end = col_sum >= {1'b0, texture_width};
  assign widx    = 18'(a_index);

  // per-dot decision: blank, bank color or lookup entry, and end-code count
  always_comb begin
    kind                = sppd_pkg::PK_ZERO;
    end_code_count_next = end_code_count;
    addr_full           = '0;
    unique case (mode)
      sppd_pkg::MODE_BANK4: begin
        addr_full = 18'({color_base[15:4], color_base[3:0] | dot[3:0]});
        if (dot != sppd_pkg::TRANSPARENT_DOT) begin
          kind = sppd_pkg::PK_BANK;
        end
      end
      sppd_pkg::MODE_BANK8: begin
        addr_full = 18'(color_base) + 18'(dot);
        if (dot != sppd_pkg::TRANSPARENT_DOT) begin
          kind = sppd_pkg::PK_BANK;
        end
      end
      sppd_pkg::MODE_LUT4: begin
        addr_full = {color_base, 2'b00} + 18'(dot);
        if (!draw_mode[sppd_pkg::DM_END_OFF_BIT] &&
            (end_code_count >= sppd_pkg::END_CODE_LIMIT)) begin
          kind = sppd_pkg::PK_ZERO;
        end else if ((dot == sppd_pkg::TRANSPARENT_DOT) &&
                     !draw_mode[sppd_pkg::DM_SPD_BIT]) begin
          kind = sppd_pkg::PK_ZERO;
        end else if ((dot == sppd_pkg::LUT_END_DOT) &&
                     !draw_mode[sppd_pkg::DM_ENDC_BIT]) begin
          kind = sppd_pkg::PK_ZERO;
          if (end_code_count < sppd_pkg::END_CODE_LIMIT) begin
            end_code_count_next = end_code_count + 2'd1;
          end
        end else begin
          kind = sppd_pkg::PK_LUT;
        end
      end
      default: ;
    endcase
  end

  sppd_ram #(
    .WIDTH(16),
    .DEPTH(TABLE_WORDS)
  ) u_table (
    .clk  (clk),
    .we   (is_write),
    .waddr(widx[AW-1:0]),
    .wdata(a_word),
    .re   (issue),
    .raddr(addr_full[AW-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    unique case (b_tag.kind)
      sppd_pkg::PK_BANK: rgba_comb = sppd_pkg::expand555(rdata);
      sppd_pkg::PK_LUT: begin
        if (!rdata[15]) begin
          rgba_comb = '0;
        end else if (b_tag.msb) begin
          rgba_comb = sppd_pkg::OPAQUE_BLACK;
        end else begin
          rgba_comb = sppd_pkg::expand555(rdata);
        end
      end
      default: rgba_comb = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_mode      <= '0;
      color_base     <= '0;
      texture_width  <= sppd_pkg::TEX_WIDTH_RESET;
      column_count   <= '0;
      end_code_count <= '0;
      a_valid        <= 1'b0;
      a_phase        <= 1'b0;
      b_valid        <= 1'b0;
      c_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sppd_pkg::CFG_DRAW_MODE: begin
            draw_mode      <= cfg_data;
            column_count   <= '0;
            end_code_count <= '0;
          end
          sppd_pkg::CFG_COLOR_BASE: begin
            color_base     <= cfg_data;
            column_count   <= '0;
            end_code_count <= '0;
          end
          sppd_pkg::CFG_TEX_WIDTH: begin
            texture_width  <= cfg_data[8:0];
            column_count   <= '0;
            end_code_count <= '0;
          end
          default: ;
        endcase
      end else if (issue) begin
        if (a_done && row_end) begin
          column_count   <= '0;
          end_code_count <= '0;
        end else begin
          end_code_count <= end_code_count_next;
          if (a_done) begin
            column_count <= col_sum[8:0];
          end
        end
      end

      if (issue && is_4bpp && !a_phase) begin
        a_phase <= 1'b1;
      end
      if (accept) begin
        a_valid <= 1'b1;
        a_phase <= 1'b0;
      end else if (a_done) begin
        a_valid <= 1'b0;
      end

      if (b_free) begin
        b_valid <= issue;
      end
      if (c_free) begin
        c_valid <= b_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      a_op    <= item.op;
      a_index <= item.table_index;
      a_word  <= item.table_word;
      a_byte  <= item.source_byte;
    end
    if (issue) begin
      b_tag.kind <= kind;
      b_tag.msb  <= draw_mode[sppd_pkg::DM_MSB_BIT];
      b_tag.last <= !is_4bpp || a_phase;
    end
    if (b_valid && c_free) begin
      c_rgba <= rgba_comb;
      c_last <= b_tag.last;
    end
  end

  assign pixel.valid        = c_valid;
  assign pixel.pixel_rgba   = c_rgba;
  assign pixel.last_of_item = c_last;

endmodule

FILE: rtl/core/sppd_ram.sv
`timescale 1ns / 1ps

module sppd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/sppd_checker.sv
`timescale 1ns / 1ps
`include "sprite_palette_pixel_decoder_defines.svh"

module sppd_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_ready,
  input logic        pixel_valid,
  input logic        pixel_ready,
  input logic [31:0] pixel_rgba,
  input logic        last_of_item
);

  // a stalled pixel stays offered and unchanged
  `SPPD_ASSERT_NEXT(a_pixel_hold, clk, rst, pixel_valid && !pixel_ready, pixel_valid)
  `SPPD_ASSERT_NEXT(a_pixel_stable, clk, rst, pixel_valid && !pixel_ready, $stable(pixel_rgba) && $stable(last_of_item))

  // reset empties the pipeline and frees the input side
  `SPPD_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !pixel_valid && item_ready)

  // every visible pixel is fully opaque
  `SPPD_ASSERT_NOW(a_opaque, clk, rst, pixel_valid && (pixel_rgba != 32'h0), pixel_rgba[31:24] == 8'hFF)

endmodule

bind sprite_palette_pixel_decoder sppd_checker u_sppd_checker (
  .clk         (clk),
  .rst         (rst),
  .item_ready  (item.ready),
  .pixel_valid (pixel.valid),
  .pixel_ready (pixel.ready),
  .pixel_rgba  (pixel.pixel_rgba),
  .last_of_item(pixel.last_of_item)
);
